FILE: hdl/irt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irt_pkg
// Shared types and constants for the IPv4 range table and address walker.
// ----------------------------------------------------------------------------
package irt_pkg;

    localparam int MAX_RANGES = 256;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int ADDR_W     = 32;
    localparam int WALK_W     = ADDR_W + 1;
    localparam int TOTAL_W    = 41;

    localparam logic [ADDR_W-1:0]  OCTET_KEEP = 32'hFFFF_FF00;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;
    localparam logic [5:0]         PREFIX_MAX = 6'd32;

    typedef enum logic [2:0] {
        REQ_ADD_PREFIX = 3'd0,
        REQ_ADD_RANGE  = 3'd1,
        REQ_ADD_OCTET  = 3'd2,
        REQ_NEXT       = 3'd3,
        REQ_REWIND     = 3'd4,
        REQ_CLEAR      = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_BAD_PREFIX      = 3'd1,
        ST_ZERO_ADDR       = 3'd2,
        ST_START_AFTER_END = 3'd3,
        ST_FULL            = 3'd4,
        ST_EXHAUSTED       = 3'd5
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [ADDR_W-1:0] address;
        logic [5:0]        prefix_len;
        logic [ADDR_W-1:0] end_address;
        logic [7:0]        last_octet;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic               addr_valid;
        logic [ADDR_W-1:0]  addr_out;
        logic [TOTAL_W-1:0] total_count;
        logic [CNT_W-1:0]   ranges_stored;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
    } t_range;

    typedef struct packed {
        logic              is_add;
        t_status           status;
        t_range            range;
    } t_add_chk;

endpackage : irt_pkg
`default_nettype wire

FILE: hdl/irt_range_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irt_range_mem
// Range table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module irt_range_mem (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [irt_pkg::IDX_W-1:0] i_wr_addr,
    input  wire irt_pkg::t_range          i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [irt_pkg::IDX_W-1:0] i_rd_addr,
    output irt_pkg::t_range               o_rd_data
);

    irt_pkg::t_range r_mem [irt_pkg::MAX_RANGES];
    irt_pkg::t_range r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule : irt_range_mem
`default_nettype wire

FILE: hdl/irt_add_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irt_add_check
// Decode an add request into a range and check it for form errors.
// ----------------------------------------------------------------------------
module irt_add_check (
    input  wire irt_pkg::t_in_item i_item,
    output irt_pkg::t_add_chk      o_chk
);

    logic [irt_pkg::ADDR_W-1:0] w_mask;
    logic [irt_pkg::ADDR_W-1:0] w_octet_hi;

    assign w_mask     = ~({irt_pkg::ADDR_W{1'b1}} >> i_item.prefix_len);
    assign w_octet_hi = (i_item.address & irt_pkg::OCTET_KEEP) |
                        {{(irt_pkg::ADDR_W-8){1'b0}}, i_item.last_octet};

    always_comb begin
        o_chk.is_add   = 1'b0;
        o_chk.status   = irt_pkg::ST_OK;
        o_chk.range.lo = i_item.address;
        o_chk.range.hi = i_item.end_address;
        unique case (i_item.req_type)
            irt_pkg::REQ_ADD_PREFIX: begin
                o_chk.is_add   = 1'b1;
                o_chk.range.lo = i_item.address & w_mask;
                o_chk.range.hi = (i_item.address & w_mask) | ~w_mask;
                if (i_item.prefix_len > irt_pkg::PREFIX_MAX) begin
                    o_chk.status = irt_pkg::ST_BAD_PREFIX;
                end
            end
            irt_pkg::REQ_ADD_RANGE: begin
                o_chk.is_add = 1'b1;
                if (i_item.address == '0 || i_item.end_address == '0) begin
                    o_chk.status = irt_pkg::ST_ZERO_ADDR;
                end else if (i_item.address > i_item.end_address) begin
                    o_chk.status = irt_pkg::ST_START_AFTER_END;
                end
            end
            irt_pkg::REQ_ADD_OCTET: begin
                o_chk.is_add   = 1'b1;
                o_chk.range.hi = w_octet_hi;
                if (i_item.address == '0) begin
                    o_chk.status = irt_pkg::ST_ZERO_ADDR;
                end else if (i_item.address > w_octet_hi) begin
                    o_chk.status = irt_pkg::ST_START_AFTER_END;
                end
            end
            default: begin
                o_chk.is_add = 1'b0;
            end
        endcase
    end

endmodule : irt_add_check
`default_nettype wire

FILE: hdl/ip_range_table_address_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ip_range_table_address_generator
// Results: add, rewind, clear and an exhausted next load the output register
// on acceptance; a next that reads the table waits in the walk state for one
// registered table read per range it visits, then loads the output register.
// Flow: one transaction at a time; input stalls while walking or output stalls.
// Reset: synchronous, active low; clears counters, walk state and output valid.
// ----------------------------------------------------------------------------
module ip_range_table_address_generator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire irt_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output irt_pkg::t_out_item      o_out_data
);

    irt_pkg::t_state               r_state, n_state;
    logic [irt_pkg::CNT_W-1:0]     r_stored, n_stored;
    logic [irt_pkg::TOTAL_W-1:0]   r_total, n_total;
    logic [irt_pkg::CNT_W-1:0]     r_walk_index, n_walk_index;
    logic [irt_pkg::WALK_W-1:0]    r_walk_addr, n_walk_addr;
    logic                          r_walk_fresh, n_walk_fresh;
    logic                          r_out_valid, n_out_valid;
    irt_pkg::t_out_item            r_out_data, n_out_data;

    irt_pkg::t_add_chk             w_chk;
    irt_pkg::t_range               w_rd_data;
    logic                          w_accept;
    logic                          w_load;
    logic                          w_wr_en;
    logic                          w_rd_en;
    logic [irt_pkg::IDX_W-1:0]     w_rd_addr;
    logic [irt_pkg::CNT_W-1:0]     w_index_inc;
    logic                          w_has_range;
    logic                          w_more;
    logic [irt_pkg::WALK_W-1:0]    w_cand;
    logic                          w_hit;
    logic                          w_full;
    logic [irt_pkg::TOTAL_W:0]     w_sum;

    irt_add_check u_add_check (
        .i_item (i_in_data),
        .o_chk  (w_chk)
    );

    irt_range_mem u_range_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_stored[irt_pkg::IDX_W-1:0]),
        .i_wr_data (w_chk.range),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_in_stall  = (r_state != irt_pkg::S_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_index_inc = r_walk_index + 1'b1;
    assign w_has_range = r_walk_index < r_stored;
    assign w_more      = w_index_inc < r_stored;
    assign w_cand      = r_walk_fresh ? {1'b0, w_rd_data.lo} : r_walk_addr;
    assign w_hit       = w_cand <= {1'b0, w_rd_data.hi};
    assign w_full      = r_stored >= irt_pkg::CNT_W'(irt_pkg::MAX_RANGES);
    assign w_sum       = {1'b0, r_total} +
                         (irt_pkg::TOTAL_W+1)'({1'b0, w_chk.range.hi - w_chk.range.lo}) +
                         1'b1;
    assign w_wr_en     = w_accept && w_chk.is_add && (w_chk.status == irt_pkg::ST_OK) &&
                         !w_full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            irt_pkg::S_IDLE: begin
                if (w_accept && (i_in_data.req_type == irt_pkg::REQ_NEXT) && w_has_range) begin
                    n_state = irt_pkg::S_WALK;
                end
            end
            irt_pkg::S_WALK: begin
                if (w_hit || !w_more) begin
                    n_state = irt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = irt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_stored     = r_stored;
        n_total      = r_total;
        n_walk_index = r_walk_index;
        n_walk_addr  = r_walk_addr;
        n_walk_fresh = r_walk_fresh;
        w_load       = 1'b0;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_walk_index[irt_pkg::IDX_W-1:0];
        n_out_data.status     = irt_pkg::ST_OK;
        n_out_data.addr_valid = 1'b0;
        n_out_data.addr_out   = '0;
        unique case (r_state)
            irt_pkg::S_IDLE: begin
                if (w_accept) begin
                    w_load = 1'b1;
                    if (w_chk.is_add) begin
                        if (w_chk.status != irt_pkg::ST_OK) begin
                            n_out_data.status = w_chk.status;
                        end else if (w_full) begin
                            n_out_data.status = irt_pkg::ST_FULL;
                        end else begin
                            n_stored = r_stored + 1'b1;
                            n_total  = w_sum[irt_pkg::TOTAL_W] ? irt_pkg::TOTAL_MAX :
                                       w_sum[irt_pkg::TOTAL_W-1:0];
                        end
                    end else begin
                        unique case (i_in_data.req_type)
                            irt_pkg::REQ_NEXT: begin
                                if (w_has_range) begin
                                    w_load  = 1'b0;
                                    w_rd_en = 1'b1;
                                end else begin
                                    n_out_data.status = irt_pkg::ST_EXHAUSTED;
                                end
                            end
                            irt_pkg::REQ_REWIND: begin
                                n_walk_index = '0;
                                n_walk_addr  = '0;
                                n_walk_fresh = 1'b1;
                            end
                            irt_pkg::REQ_CLEAR: begin
                                n_stored     = '0;
                                n_total      = '0;
                                n_walk_index = '0;
                                n_walk_addr  = '0;
                                n_walk_fresh = 1'b1;
                            end
                            default: begin
                                n_out_data.status = irt_pkg::ST_OK;
                            end
                        endcase
                    end
                end
            end
            irt_pkg::S_WALK: begin
                if (w_hit) begin
                    w_load                = 1'b1;
                    n_out_data.addr_valid = 1'b1;
                    n_out_data.addr_out   = w_cand[irt_pkg::ADDR_W-1:0];
                    n_walk_addr           = w_cand + 1'b1;
                    n_walk_fresh          = 1'b0;
                end else begin
                    n_walk_index = w_index_inc;
                    n_walk_fresh = 1'b1;
                    if (w_more) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_index_inc[irt_pkg::IDX_W-1:0];
                    end else begin
                        w_load            = 1'b1;
                        n_out_data.status = irt_pkg::ST_EXHAUSTED;
                    end
                end
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
        n_out_data.total_count   = n_total;
        n_out_data.ranges_stored = n_stored;
        n_out_valid              = w_load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= irt_pkg::S_IDLE;
            r_stored     <= '0;
            r_total      <= '0;
            r_walk_index <= '0;
            r_walk_addr  <= '0;
            r_walk_fresh <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_stored     <= n_stored;
            r_total      <= n_total;
            r_walk_index <= n_walk_index;
            r_walk_addr  <= n_walk_addr;
            r_walk_fresh <= n_walk_fresh;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule : ip_range_table_address_generator
`default_nettype wire
